// ----- rtl/asr_pkg.sv -----
package asr_pkg;

    localparam int MAX_FRAME_BYTES = 3;

    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [7:0] CRC_FINAL_XOR = 8'h55;

    // operation codes
    localparam logic [1:0] OP_READ_ANGLE = 2'd0;
    localparam logic [1:0] OP_READ_REG   = 2'd1;
    localparam logic [1:0] OP_WRITE_REG  = 2'd2;
    localparam logic [1:0] OP_RESERVED   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_ANGLE_CMD   = 2'd1;
    localparam logic [1:0] CFG_RD_REG_CMD  = 2'd2;
    localparam logic [1:0] CFG_WR_REG_CMD  = 2'd3;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] read_angle_command;
        logic [7:0] read_register_command;
        logic [7:0] write_register_command;
    } asr_cfg_t;

    // field order follows m_tdata from the top bit down
    typedef struct packed {
        logic        rejected;
        logic        crc_ok;
        logic [7:0]  register_value;
        logic [15:0] angle;
        logic        done_res;
        logic        busy_res;
        logic        chip_select_n;
        logic        line_drive_enable;
        logic        line_out;
        logic        clock_pin;
    } asr_result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/asr_seq.sv -----
module asr_seq
    import asr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        kind,
    input  logic [1:0]  operation,
    input  logic [7:0]  register_address,
    input  logic [7:0]  write_value,
    input  logic        line_in,
    input  asr_cfg_t    cfg,
    output asr_result_t result
);

    logic       active_reg, active_next;
    logic [1:0] cur_op_reg, cur_op_next;
    logic       receiving_reg, receiving_next;
    logic       low_half_reg, low_half_next;
    logic [7:0] tick_reg, tick_next;
    logic [2:0] bit_reg, bit_next;
    logic [1:0] byte_reg, byte_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] crc_reg, crc_next;

    logic [7:0] tx1_reg, tx2_reg;
    logic [7:0] rx_byte_reg [0:MAX_FRAME_BYTES-1];

    logic       load_tx;
    logic       rx_wr;
    logic [7:0] hp;
    logic [7:0] tick_inc;
    logic [1:0] byte_inc;
    logic       last_rx;
    logic [7:0] expect_crc;
    logic       drive;

    assign hp       = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
    assign tick_inc = tick_reg + 8'd1;
    assign byte_inc = byte_reg + 2'd1;
    // reply length is three minus the operation code
    assign last_rx  = ({1'b0, byte_inc} >= (3'd3 - {1'b0, cur_op_reg})) || (byte_inc == 2'd3);
    assign expect_crc = crc_reg ^ CRC_FINAL_XOR;

    always_comb begin
        active_next    = active_reg;
        cur_op_next    = cur_op_reg;
        receiving_next = receiving_reg;
        low_half_next  = low_half_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        shift_next     = shift_reg;
        crc_next       = crc_reg;
        load_tx        = 1'b0;
        rx_wr          = 1'b0;
        result         = '0;

        if (kind) begin
            if (active_reg || operation == OP_RESERVED) begin
                result.rejected = 1'b1;
            end else begin
                load_tx        = 1'b1;
                cur_op_next    = operation;
                case (operation)
                    OP_READ_ANGLE: shift_next = cfg.read_angle_command;
                    OP_READ_REG:   shift_next = cfg.read_register_command;
                    default:       shift_next = cfg.write_register_command;
                endcase
                active_next    = 1'b1;
                receiving_next = 1'b0;
                low_half_next  = 1'b1;
                tick_next      = '0;
                bit_next       = '0;
                byte_next      = '0;
                crc_next       = '0;
            end
        end else if (active_reg) begin
            tick_next = tick_inc;
            if (tick_inc >= hp) begin
                tick_next = '0;
                if (low_half_reg) begin
                    if (receiving_reg) begin
                        shift_next = {shift_reg[6:0], line_in};
                    end
                    low_half_next = 1'b0;
                end else if (bit_reg != 3'd7) begin
                    if (!receiving_reg) begin
                        shift_next = {shift_reg[6:0], 1'b0};
                    end
                    bit_next      = bit_reg + 3'd1;
                    low_half_next = 1'b1;
                end else begin
                    bit_next      = '0;
                    low_half_next = 1'b1;
                    if (!receiving_reg) begin
                        // end of a command byte: next byte or turn the line round
                        if ({1'b0, byte_inc} >= ({1'b0, cur_op_reg} + 3'd1) ||
                            byte_inc == 2'd3) begin
                            receiving_next = 1'b1;
                            byte_next      = '0;
                            shift_next     = '0;
                        end else begin
                            byte_next  = byte_inc;
                            shift_next = (byte_inc == 2'd1) ? tx1_reg : tx2_reg;
                        end
                    end else begin
                        rx_wr      = (byte_reg != 2'd3);
                        byte_next  = byte_inc;
                        shift_next = '0;
                        if (!last_rx) begin
                            crc_next = crc8_step(crc_reg, shift_reg);
                        end else begin
                            active_next     = 1'b0;
                            receiving_next  = 1'b0;
                            low_half_next   = 1'b0;
                            byte_next       = '0;
                            result.done_res = 1'b1;
                            case (cur_op_reg)
                                OP_READ_ANGLE: begin
                                    result.angle  = {rx_byte_reg[0], rx_byte_reg[1]};
                                    result.crc_ok = (expect_crc == shift_reg);
                                end
                                OP_READ_REG: begin
                                    result.register_value = rx_byte_reg[0];
                                    result.crc_ok         = (expect_crc == shift_reg);
                                end
                                default: begin
                                    result.register_value = shift_reg;
                                end
                            endcase
                        end
                    end
                end
            end
        end

        drive                    = active_next && !receiving_next;
        result.clock_pin         = !(active_next && low_half_next);
        result.line_out          = drive && shift_next[7];
        result.line_drive_enable = drive;
        result.chip_select_n     = !active_next;
        result.busy_res          = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            cur_op_reg    <= '0;
            receiving_reg <= 1'b0;
            low_half_reg  <= 1'b0;
            tick_reg      <= '0;
            bit_reg       <= '0;
            byte_reg      <= '0;
            shift_reg     <= '0;
            crc_reg       <= '0;
        end else if (step) begin
            active_reg    <= active_next;
            cur_op_reg    <= cur_op_next;
            receiving_reg <= receiving_next;
            low_half_reg  <= low_half_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            byte_reg      <= byte_next;
            shift_reg     <= shift_next;
            crc_reg       <= crc_next;
        end
    end

    // frame bytes, no reset needed
    always_ff @(posedge aclk) begin
        if (step && load_tx) begin
            tx1_reg <= register_address;
            tx2_reg <= write_value;
        end
        if (step && rx_wr) begin
            rx_byte_reg[byte_reg] <= shift_reg;
        end
    end

endmodule

// ----- rtl/angle_sensor_spi3_reader.sv -----
// A result is registered and appears on m_tdata in the cycle after its input transfer.
// One item per cycle while the output is not stalled: the sequencer step and the
// output register both load on each transfer, so a tick can be taken every cycle.
// A stalled output holds its result; the input is still taken in the cycle
// the output is being emptied.
// Reset (aresetn low, synchronous) idles the bus: SCK high, CS high, line released.
module angle_sensor_spi3_reader
    import asr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [9:2] register_address, [17:10] write_value, [18] line_in
    input  logic [23:0] s_tdata,
    // [0] kind
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] clock_pin, [1] line_out, [2] line_drive_enable, [3] chip_select_n,
    // [4] busy_res, [5] done_res, [21:6] angle, [29:22] register_value,
    // [30] crc_ok, [31] rejected
    output logic [31:0] m_tdata
);

    asr_cfg_t    cfg_reg;
    asr_result_t result;
    asr_result_t m_tdata_reg;
    logic        m_tvalid_reg;
    logic        step;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks      <= 8'd1;
            cfg_reg.read_angle_command     <= '0;
            cfg_reg.read_register_command  <= '0;
            cfg_reg.write_register_command <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks      <= cfg_wdata;
                CFG_ANGLE_CMD:   cfg_reg.read_angle_command     <= cfg_wdata;
                CFG_RD_REG_CMD:  cfg_reg.read_register_command  <= cfg_wdata;
                CFG_WR_REG_CMD:  cfg_reg.write_register_command <= cfg_wdata;
                default:         cfg_reg.half_period_ticks      <= cfg_reg.half_period_ticks;
            endcase
        end
    end

    asr_seq u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .kind             (s_tuser),
        .operation        (s_tdata[1:0]),
        .register_address (s_tdata[9:2]),
        .write_value      (s_tdata[17:10]),
        .line_in          (s_tdata[18]),
        .cfg              (cfg_reg),
        .result           (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/asr_checker.sv -----
module asr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // a finished transfer releases the bus
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[3] && !m_tdata[4] && !m_tdata[2] && m_tdata[0])
        else $error("done while bus still held");

    a_crc_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30] |-> m_tdata[5])
        else $error("crc_ok outside done");

    a_sck_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (!m_tdata[0] || m_tdata[2]) |-> !m_tdata[3] && m_tdata[4])
        else $error("bus activity with chip select high");

endmodule

bind angle_sensor_spi3_reader asr_checker u_asr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/angle_sensor_spi3_reader_test.sv -----
module angle_sensor_spi3_reader_test;
    timeunit 1ns;
    timeprecision 1ps;

    import asr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic       kind;
        logic [1:0] op;
        logic [7:0] addr;
        logic [7:0] wval;
        logic       line_in;
    } sensor_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    angle_sensor_spi3_reader DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    sensor_cmd_t pending_cmds[$];
    asr_result_t expected_status[$];
    int          items_queued = 0;
    int          items_taken = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          gen_half = 1;

    // configuration copy as the block holds it
    logic [7:0] set_half = 8'd1;
    logic [7:0] set_angle_cmd = 8'h00;
    logic [7:0] set_rdreg_cmd = 8'h00;
    logic [7:0] set_wrreg_cmd = 8'h00;

    // sequencer state of the predicted bus master
    logic       bus_active = 1'b0;
    logic [1:0] bus_op = '0;
    logic       bus_receiving = 1'b0;
    logic       bus_low_half = 1'b0;
    logic [7:0] bus_ticks = '0;
    logic [2:0] bus_bit = '0;
    logic [1:0] bus_byte = '0;
    logic [7:0] bus_tx [0:2] = '{default: 8'h00};
    logic [7:0] bus_shift = '0;
    logic [7:0] bus_rx [0:2] = '{default: 8'h00};
    logic [7:0] bus_crc = '0;

    sensor_cmd_t next_cmd;
    sensor_cmd_t taken_cmd;
    asr_result_t want_status;
    asr_result_t seen_status;

    // bit-serial form, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic asr_result_t predict_bus_state(input sensor_cmd_t c);
        asr_result_t r;
        int          hp;
        logic        last;
        logic [7:0]  want_crc;
        logic        drive;
        r = '0;
        if (c.kind) begin
            if (bus_active || c.op == OP_RESERVED) begin
                r.rejected = 1'b1;
            end else begin
                bus_op = c.op;
                bus_tx[0] = (c.op == OP_READ_ANGLE) ? set_angle_cmd :
                            (c.op == OP_READ_REG) ? set_rdreg_cmd : set_wrreg_cmd;
                bus_tx[1] = c.addr;
                bus_tx[2] = c.wval;
                bus_shift = bus_tx[0];
                bus_active = 1'b1;
                bus_receiving = 1'b0;
                bus_low_half = 1'b1;
                bus_ticks = '0;
                bus_bit = '0;
                bus_byte = '0;
                bus_crc = '0;
            end
        end else if (bus_active) begin
            hp = (set_half == 8'd0) ? 1 : int'(set_half);
            bus_ticks = bus_ticks + 8'd1;
            if (int'(bus_ticks) >= hp) begin
                bus_ticks = '0;
                if (bus_low_half) begin
                    if (bus_receiving) bus_shift = {bus_shift[6:0], c.line_in};
                    bus_low_half = 1'b0;
                end else begin
                    if (!bus_receiving) bus_shift = {bus_shift[6:0], 1'b0};
                    if (bus_bit != 3'd7) begin
                        bus_bit = bus_bit + 3'd1;
                        bus_low_half = 1'b1;
                    end else begin
                        bus_bit = '0;
                        if (!bus_receiving) begin
                            bus_byte = bus_byte + 2'd1;
                            if (int'(bus_byte) >= int'(bus_op) + 1) begin
                                bus_receiving = 1'b1;
                                bus_byte = '0;
                                bus_shift = '0;
                            end else begin
                                bus_shift = bus_tx[bus_byte];
                            end
                            bus_low_half = 1'b1;
                        end else begin
                            last = (int'(bus_byte) + 1 >= MAX_FRAME_BYTES - int'(bus_op));
                            bus_rx[bus_byte] = bus_shift;
                            bus_byte = bus_byte + 2'd1;
                            bus_shift = '0;
                            if (!last) begin
                                bus_crc = crc8_update(bus_crc, bus_rx[bus_byte - 2'd1]);
                                bus_low_half = 1'b1;
                            end else begin
                                want_crc = bus_crc ^ CRC_FINAL_XOR;
                                bus_active = 1'b0;
                                bus_receiving = 1'b0;
                                bus_low_half = 1'b0;
                                bus_byte = '0;
                                r.done_res = 1'b1;
                                case (bus_op)
                                    OP_READ_ANGLE: begin
                                        r.angle = {bus_rx[0], bus_rx[1]};
                                        r.crc_ok = (want_crc == bus_rx[2]);
                                    end
                                    OP_READ_REG: begin
                                        r.register_value = bus_rx[0];
                                        r.crc_ok = (want_crc == bus_rx[1]);
                                    end
                                    default: begin
                                        r.register_value = bus_rx[0];
                                    end
                                endcase
                            end
                        end
                    end
                end
            end
        end
        drive = bus_active && !bus_receiving;
        r.clock_pin = !(bus_active && bus_low_half);
        r.line_out = drive ? bus_shift[7] : 1'b0;
        r.line_drive_enable = drive;
        r.chip_select_n = !bus_active;
        r.busy_res = bus_active;
        return r;
    endfunction

    function automatic sensor_cmd_t make_cmd(input logic kind, input logic [1:0] op,
                                             input logic [7:0] addr, input logic [7:0] wval,
                                             input logic li);
        sensor_cmd_t c;
        c.kind = kind;
        c.op = op;
        c.addr = addr;
        c.wval = wval;
        c.line_in = li;
        return c;
    endfunction

    task automatic enqueue(input sensor_cmd_t c);
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    function automatic sensor_cmd_t random_cmd(input logic kind, input logic li);
        return make_cmd(kind, 2'($urandom_range(3)), 8'($urandom), 8'($urandom), li);
    endfunction

    // a tick inside a transaction; now and then a start arrives while busy
    task automatic enqueue_tick(input logic li);
        if ($urandom_range(127) == 0) enqueue(random_cmd(1'b1, 1'($urandom_range(1))));
        enqueue(random_cmd(1'b0, li));
    endtask

    // one complete well-formed transaction; the reply bits are held on line_in
    // for a whole SCK period so the sample point falls inside it
    task automatic queue_transaction(input logic [1:0] op, input logic [7:0] addr,
                                     input logic [7:0] wval, input logic [7:0] d0,
                                     input logic [7:0] d1, input bit crc_good,
                                     input bit noisy, input bit poke);
        logic [7:0] reply [0:2];
        logic [7:0] crc;
        int         rx_bytes;
        rx_bytes = MAX_FRAME_BYTES - int'(op);
        reply[0] = d0;
        reply[1] = d1;
        reply[2] = 8'h00;
        crc = 8'h00;
        for (int i = 0; i < rx_bytes - 1; i++) crc = crc8_update(crc, reply[i]);
        crc = crc ^ CRC_FINAL_XOR;
        if (!crc_good) crc = crc ^ 8'($urandom_range(255, 1));
        if (rx_bytes > 1) reply[rx_bytes - 1] = crc;
        enqueue(make_cmd(1'b1, op, addr, wval, 1'($urandom_range(1))));
        if (poke) enqueue(random_cmd(1'b1, 1'($urandom_range(1))));
        for (int t = 0; t < 16 * gen_half * (int'(op) + 1); t++) begin
            enqueue_tick(1'($urandom_range(1)));
        end
        for (int i = 0; i < rx_bytes; i++) begin
            for (int b = 7; b >= 0; b--) begin
                for (int k = 0; k < 2 * gen_half; k++) begin
                    enqueue_tick(noisy ? 1'($urandom_range(1)) : reply[i][b]);
                end
            end
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_traffic(input int budget);
        int first;
        first = items_queued;
        while (items_queued - first < budget) begin
            repeat ($urandom_range(3)) enqueue(random_cmd(1'b0, 1'($urandom_range(1))));
            if ($urandom_range(5) == 0) begin
                enqueue(make_cmd(1'b1, OP_RESERVED, 8'($urandom), 8'($urandom),
                                 1'($urandom_range(1))));
            end
            queue_transaction(2'($urandom_range(2)), pick_byte(), pick_byte(), pick_byte(),
                              pick_byte(), $urandom_range(3) != 0, $urandom_range(7) == 0,
                              $urandom_range(3) == 0);
        end
    endtask

    task automatic drain();
        while (items_taken != items_queued || expected_status.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] half, input logic [7:0] angle_cmd,
                              input logic [7:0] rd_cmd, input logic [7:0] wr_cmd);
        drain();
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_ANGLE_CMD, angle_cmd);
        write_reg(CFG_RD_REG_CMD, rd_cmd);
        write_reg(CFG_WR_REG_CMD, wr_cmd);
        gen_half = (half == 8'd0) ? 1 : int'(half);
        @(negedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_cmd = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {5'b0, next_cmd.line_in, next_cmd.wval, next_cmd.addr, next_cmd.op};
                s_tuser <= next_cmd.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks the result side, then records what went in this edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
            if (m_tvalid && m_tready) begin
                seen_status = m_tdata;
                if (expected_status.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: result with nothing expected: %h", $realtime, m_tdata);
                    end
                    mismatch_count++;
                end else begin
                    want_status = expected_status.pop_front();
                    if (seen_status.clock_pin !== want_status.clock_pin ||
                        seen_status.line_out !== want_status.line_out ||
                        seen_status.line_drive_enable !== want_status.line_drive_enable ||
                        seen_status.chip_select_n !== want_status.chip_select_n ||
                        seen_status.busy_res !== want_status.busy_res ||
                        seen_status.done_res !== want_status.done_res ||
                        seen_status.angle !== want_status.angle ||
                        seen_status.register_value !== want_status.register_value ||
                        seen_status.crc_ok !== want_status.crc_ok ||
                        seen_status.rejected !== want_status.rejected) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: mismatch sck/dout/oe/csn/busy/done/angle/reg/crc/rej",
                                     $realtime);
                            $display("  expected %b %b %b %b %b %b %h %h %b %b",
                                     want_status.clock_pin, want_status.line_out,
                                     want_status.line_drive_enable, want_status.chip_select_n,
                                     want_status.busy_res, want_status.done_res,
                                     want_status.angle, want_status.register_value,
                                     want_status.crc_ok, want_status.rejected);
                            $display("  actual   %b %b %b %b %b %b %h %h %b %b",
                                     seen_status.clock_pin, seen_status.line_out,
                                     seen_status.line_drive_enable, seen_status.chip_select_n,
                                     seen_status.busy_res, seen_status.done_res,
                                     seen_status.angle, seen_status.register_value,
                                     seen_status.crc_ok, seen_status.rejected);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_HALF_PERIOD: set_half = cfg_wdata;
                    CFG_ANGLE_CMD:   set_angle_cmd = cfg_wdata;
                    CFG_RD_REG_CMD:  set_rdreg_cmd = cfg_wdata;
                    CFG_WR_REG_CMD:  set_wrreg_cmd = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                taken_cmd = make_cmd(s_tuser, s_tdata[1:0], s_tdata[9:2], s_tdata[17:10],
                                     s_tdata[18]);
                expected_status.push_back(predict_bus_state(taken_cmd));
                items_taken++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("angle_sensor_spi3_reader verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: command byte extremes, every operation, corner cases
        set_idling(0, 0);
        set_config(8'd1, 8'h00, 8'hFF, 8'h80);
        enqueue(make_cmd(1'b0, OP_READ_ANGLE, 8'hFF, 8'hFF, 1'b1));
        enqueue(make_cmd(1'b0, OP_RESERVED, 8'h00, 8'h00, 1'b0));
        enqueue(make_cmd(1'b1, OP_RESERVED, 8'hFF, 8'h00, 1'b1));
        queue_transaction(OP_READ_ANGLE, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1);
        queue_transaction(OP_READ_ANGLE, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_transaction(OP_READ_REG, 8'hFF, 8'h00, 8'hA5, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_transaction(OP_READ_REG, 8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_transaction(OP_WRITE_REG, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_transaction(OP_WRITE_REG, 8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_transaction(OP_READ_ANGLE, 8'h5A, 8'hA5, 8'h12, 8'h34, 1'b1, 1'b1, 1'b0);

        // zero half period behaves as one tick
        set_config(8'd0, 8'($urandom), 8'($urandom), 8'($urandom));
        set_idling(55, 0);
        random_traffic(200);

        set_config(8'd2, 8'($urandom), 8'($urandom), 8'($urandom));
        set_idling(0, 55);
        random_traffic(200);

        set_config(8'd3, 8'($urandom), 8'($urandom), 8'($urandom));
        set_idling(24, 24);
        random_traffic(150);

        // sender holds off until every transfer has come back
        set_config(8'd1, 8'hFF, 8'h00, 8'h7F);
        set_idling(0, 0);
        random_traffic(100);
        drain();
        set_idling(55, 55);
        random_traffic(100);

        // longest half period: the first SCK low half runs its full length
        set_config(8'd255, 8'($urandom), 8'($urandom), 8'($urandom));
        set_idling(0, 0);
        enqueue(make_cmd(1'b1, OP_READ_REG, pick_byte(), pick_byte(), 1'b0));
        for (int t = 0; t < 260; t++) enqueue_tick(1'($urandom_range(1)));

        drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("angle_sensor_spi3_reader verification clean");
        end else begin
            $display("angle_sensor_spi3_reader verification failed");
        end
        $finish;
    end

endmodule
